>>> design/csem_pkg.sv
// Shared types and constants for the counting semaphore table.
// Used by csem_ctrl, csem_dp and counting_semaphore_table; no dependencies.
package csem_pkg;

  // Fixed field widths
  localparam int CountW     = 9;   // signed semaphore count
  localparam int PidW       = 8;   // pid port width
  localparam int SemIdxW    = 4;   // semaphore index port width
  localparam int SemsInUseW = 4;   // sems_in_use register width
  localparam int CfgDataW   = 64;  // widest register (initial_counts)
  localparam int CfgIdxW    = 1;   // two registers
  localparam int StartCntW  = 8;   // one packed start count

  // Requested operation
  localparam logic FuncWait   = 1'b0;
  localparam logic FuncSignal = 1'b1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgSemsInUse    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgInitialCounts = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    StProceed = 2'd0,
    StBlocked = 2'd1,
    StUnknown = 2'd2,
    StFull    = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic exec;      // evaluate and update counter and queue
    logic wake_rsp;  // waiter RAM data is valid, finish the wake result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic wake;      // current request pops a waiter
  } sts_t;

endpackage

>>> design/csem_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependencies.
module csem_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/csem_ctrl.sv
// Request sequencer for the counting semaphore table.
// Depends on csem_pkg (cmd_t, sts_t).
module csem_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  csem_pkg::sts_t    sts_i,
  output csem_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StRsp  = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.wake ? StRsp : StIdle;
      end
      StRsp: begin
        cmd_o.wake_rsp = 1'b1;
        state_d        = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

>>> design/csem_dp.sv
// Datapath: counters, queue pointers, waiter RAM and result registers.
// Depends on csem_pkg and csem_ram.
module csem_dp #(
  parameter int NUM_SEMS    = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_BITS    = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  csem_pkg::cmd_t                    cmd_i,
  output csem_pkg::sts_t                    sts_o,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [csem_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [csem_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // request
  input  logic                              func_i,
  input  logic [csem_pkg::SemIdxW-1:0]      sem_index_i,
  input  logic [csem_pkg::PidW-1:0]         pid_i,
  // result
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic                              woken_valid_o,
  output logic [csem_pkg::PidW-1:0]         woken_pid_o
);

  localparam int IdxW   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int PtrW   = $clog2(QUEUE_DEPTH);
  localparam int StW    = (PID_BITS < csem_pkg::PidW) ? PID_BITS : csem_pkg::PidW;
  localparam int RamD   = NUM_SEMS * QUEUE_DEPTH;
  localparam int AddrW  = $clog2(RamD);
  localparam int CntW   = csem_pkg::CountW;
  localparam logic signed [CntW:0]   NegDepth = (CntW+1)'(-QUEUE_DEPTH);
  localparam logic signed [CntW-1:0] CountMax = CntW'(255);

  // Captured request
  logic                          func_q;
  logic [csem_pkg::SemIdxW-1:0]  sem_idx_q;
  logic [StW-1:0]                pid_q;

  // Semaphore state
  logic [csem_pkg::SemsInUseW-1:0] sems_in_use_q;
  logic signed [CntW-1:0]          counts_q [NUM_SEMS];
  logic [PtrW-1:0]                 heads_q  [NUM_SEMS];
  logic [PtrW-1:0]                 tails_q  [NUM_SEMS];

  // Result registers
  logic       done_q;
  logic [1:0] status_q;
  logic       woken_valid_q;
  logic [csem_pkg::PidW-1:0] woken_pid_q;

  // Evaluation of the captured request
  logic [IdxW-1:0]        si;
  logic signed [CntW-1:0] cnt, cnt_nxt;
  logic                   known, is_wait, full, push, wake, upd;
  logic [PtrW-1:0]        head, tail;
  logic [AddrW-1:0]       base;
  csem_pkg::status_e      status_d;
  logic                   ram_we, ram_re;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  logic [StW-1:0]         ram_rdata;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  always_comb begin
    si      = sem_idx_q[IdxW-1:0];
    cnt     = counts_q[si];
    head    = heads_q[si];
    tail    = tails_q[si];
    known   = (sem_idx_q < sems_in_use_q) &&
              (sem_idx_q < csem_pkg::SemIdxW'(NUM_SEMS));
    is_wait = (func_q == csem_pkg::FuncWait);
    full    = ($signed({cnt[CntW-1], cnt}) <= NegDepth);
    push    = known && is_wait && !full && (cnt[CntW-1] || (cnt == '0));
    wake    = known && !is_wait && cnt[CntW-1];
    upd     = known && !(is_wait && full);
    base    = AddrW'(AddrW'(si) * AddrW'(QUEUE_DEPTH));

    // next count: decrement on wait, saturating increment on signal
    if (is_wait) begin
      cnt_nxt = cnt - CntW'(1);
    end else if (cnt != CountMax) begin
      cnt_nxt = cnt + CntW'(1);
    end else begin
      cnt_nxt = cnt;
    end

    priority if (!known) begin
      status_d = csem_pkg::StUnknown;
    end else if (is_wait && full) begin
      status_d = csem_pkg::StFull;
    end else if (push) begin
      status_d = csem_pkg::StBlocked;
    end else begin
      status_d = csem_pkg::StProceed;
    end
  end

  assign sts_o.wake = wake;

  // Waiter RAM access: push on a blocking wait, pop on a waking signal
  assign ram_we    = cmd_i.exec && push;
  assign ram_waddr = base + AddrW'(tail);
  assign ram_re    = cmd_i.exec && wake;
  assign ram_raddr = base + AddrW'(head);

  csem_ram #(
    .Width (StW),
    .Depth (RamD)
  ) u_waiters (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (pid_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q    <= func_i;
      sem_idx_q <= sem_index_i;
      pid_q     <= pid_i[StW-1:0];
    end
  end

  // Configuration and semaphore state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sems_in_use_q <= '0;
      for (int i = 0; i < NUM_SEMS; i++) begin
        counts_q[i] <= '0;
        heads_q[i]  <= '0;
        tails_q[i]  <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == csem_pkg::CfgSemsInUse) begin
        sems_in_use_q <= cfg_wdata_i[csem_pkg::SemsInUseW-1:0];
      end else begin
        // reload all counters, empty all queues
        for (int i = 0; i < NUM_SEMS; i++) begin
          counts_q[i] <= $signed({1'b0,
                         cfg_wdata_i[csem_pkg::StartCntW*i +: csem_pkg::StartCntW]});
          heads_q[i]  <= '0;
          tails_q[i]  <= '0;
        end
      end
    end else if (cmd_i.exec) begin
      if (upd) begin
        counts_q[si] <= cnt_nxt;
      end
      if (push) begin
        tails_q[si] <= ptr_inc(tail);
      end
      if (wake) begin
        heads_q[si] <= ptr_inc(head);
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (cmd_i.exec && !wake) || cmd_i.wake_rsp;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q      <= status_d;
      woken_valid_q <= wake;
      woken_pid_q   <= '0;
    end else if (cmd_i.wake_rsp) begin
      woken_pid_q   <= csem_pkg::PidW'(ram_rdata);
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign woken_valid_o = woken_valid_q;
  assign woken_pid_o   = woken_pid_q;

endmodule

>>> design/counting_semaphore_table.sv
// Top level of the counting semaphore table with FIFO wait queues.
// Depends on csem_pkg, csem_ctrl and csem_dp (which holds csem_ram).
//
//   Channel   Handshake             Payload
//   request   start, busy           func_i, sem_index_i, pid_i
//   result    done_o (strobe)       status_o, woken_valid_o, woken_pid_o
//   config    cfg_we_i, cfg_index_i cfg_wdata_i
//
// A request is captured at an edge with start high and busy low; the
// StExec state then updates the selected counter and queue pointer and
// registers the result strobe; for a signal that wakes a waiter, StRsp
// strobes after the registered read of the waiter RAM. busy stays high
// until then, so a new request waits for the last one to finish. Reset
// clears counts, pointers and sems_in_use; the waiter RAM needs no
// clearing. Results are strobed for one cycle and cannot be held off.
module counting_semaphore_table #(
  parameter int NUM_SEMS    = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_BITS    = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [csem_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [csem_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // request
  input  logic                              start,
  output logic                              busy,
  input  logic                              func_i,
  input  logic [csem_pkg::SemIdxW-1:0]      sem_index_i,
  input  logic [csem_pkg::PidW-1:0]         pid_i,
  // result
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic                              woken_valid_o,
  output logic [csem_pkg::PidW-1:0]         woken_pid_o
);

  csem_pkg::cmd_t cmd;
  csem_pkg::sts_t sts;

  // Sequencer
  csem_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Counters, queues and results
  csem_dp #(
    .NUM_SEMS    (NUM_SEMS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_BITS    (PID_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .func_i        (func_i),
    .sem_index_i   (sem_index_i),
    .pid_i         (pid_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .woken_valid_o (woken_valid_o),
    .woken_pid_o   (woken_pid_o)
  );

endmodule

>>> verif/csem_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the counting semaphore table: tracks counts and wait queues.
// Watches the config, request and result channels; depends on csem_pkg.
module csem_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [csem_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [csem_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic                          func_i,
  input  logic [csem_pkg::SemIdxW-1:0]  sem_index_i,
  input  logic [csem_pkg::PidW-1:0]     pid_i,
  input  logic                          done_i,
  input  logic [1:0]                    status_i,
  input  logic                          woken_valid_i,
  input  logic [csem_pkg::PidW-1:0]     woken_pid_i,
  output int                            errors_o,
  output int                            pending_o,
  output int                            results_o,
  output int                            blocked_o,
  output int                            woken_o,
  output int                            full_o,
  output int                            unknown_o
);

  localparam int NumSems    = 8;
  localparam int QueueDepth = 16;
  localparam int CountMax   = 255;

  typedef struct packed {
    csem_pkg::status_e         status;
    logic                      woken_valid;
    logic [csem_pkg::PidW-1:0] woken_pid;
  } outcome_t;

  // Shadow state of the semaphore table
  logic [csem_pkg::SemsInUseW-1:0] sems_in_use;
  int                              sem_count [NumSems];
  logic [csem_pkg::PidW-1:0]       waiters   [NumSems][$];
  outcome_t                        outcome_q [$];

  // Reload every counter from its start byte and flush all wait queues
  function automatic void reload_counts(logic [csem_pkg::CfgDataW-1:0] start_counts);
    for (int i = 0; i < NumSems; i++) begin
      sem_count[i] = int'(start_counts[csem_pkg::StartCntW*i +: csem_pkg::StartCntW]);
      waiters[i].delete();
    end
  endfunction

  // Apply one wait/signal to the shadow table and return its outcome
  function automatic outcome_t semaphore_outcome(logic op,
                                                 logic [csem_pkg::SemIdxW-1:0] idx,
                                                 logic [csem_pkg::PidW-1:0] pid);
    outcome_t res;
    int       limit;
    res        = '0;
    res.status = csem_pkg::StProceed;
    limit      = (sems_in_use > NumSems) ? NumSems : int'(sems_in_use);
    if (int'(idx) >= limit) begin
      res.status = csem_pkg::StUnknown;
    end else if (op == csem_pkg::FuncWait) begin
      if (sem_count[idx] <= -QueueDepth) begin
        res.status = csem_pkg::StFull;
      end else begin
        sem_count[idx]--;
        if (sem_count[idx] < 0) begin
          waiters[idx].push_back(pid);
          res.status = csem_pkg::StBlocked;
        end
      end
    end else begin
      // count saturates at the top
      if (sem_count[idx] < CountMax) sem_count[idx]++;
      if (sem_count[idx] <= 0) begin
        res.woken_valid = 1'b1;
        res.woken_pid   = waiters[idx].pop_front();
      end
    end
    return res;
  endfunction

  // Compare results first, then take config writes and new requests
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      sems_in_use = '0;
      reload_counts('0);
      outcome_q.delete();
      errors_o  = 0;
      pending_o = 0;
      results_o = 0;
      blocked_o = 0;
      woken_o   = 0;
      full_o    = 0;
      unknown_o = 0;
    end else begin
      if (done_i) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          errors_o++;
        end else begin
          want = outcome_q.pop_front();
          results_o++;
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            errors_o++;
          end
          if (woken_valid_i !== want.woken_valid) begin
            $error("woken_valid: expected %0d, got %0d",
                   want.woken_valid, woken_valid_i);
            errors_o++;
          end
          if (woken_pid_i !== want.woken_pid) begin
            $error("woken_pid: expected 0x%02h, got 0x%02h",
                   want.woken_pid, woken_pid_i);
            errors_o++;
          end
          if (want.status == csem_pkg::StBlocked) blocked_o++;
          if (want.status == csem_pkg::StFull)    full_o++;
          if (want.status == csem_pkg::StUnknown) unknown_o++;
          if (want.woken_valid)                   woken_o++;
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == csem_pkg::CfgSemsInUse) begin
          sems_in_use = cfg_wdata_i[csem_pkg::SemsInUseW-1:0];
        end else if (cfg_index_i == csem_pkg::CfgInitialCounts) begin
          reload_counts(cfg_wdata_i);
        end
      end
      if (start_i && !busy_i) begin
        outcome_q.push_back(semaphore_outcome(func_i, sem_index_i, pid_i));
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top of the counting semaphore table testbench: clock, reset and stimulus.
// Depends on csem_pkg, counting_semaphore_table and csem_checker.
module testbench;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [csem_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [csem_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                          start       = 1'b0;
  logic                          busy;
  logic                          func_i      = 1'b0;
  logic [csem_pkg::SemIdxW-1:0]  sem_index_i = '0;
  logic [csem_pkg::PidW-1:0]     pid_i       = '0;
  logic                          done_o;
  logic [1:0]                    status_o;
  logic                          woken_valid_o;
  logic [csem_pkg::PidW-1:0]     woken_pid_o;

  int  err_count, pending_count, result_count;
  int  blocked_count, woken_count, full_count, unknown_count;
  int  request_count = 0;
  bit  gaps_on       = 1'b1;

  counting_semaphore_table i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .sem_index_i   (sem_index_i),
    .pid_i         (pid_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .woken_valid_o (woken_valid_o),
    .woken_pid_o   (woken_pid_o)
  );

  csem_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start),
    .busy_i        (busy),
    .func_i        (func_i),
    .sem_index_i   (sem_index_i),
    .pid_i         (pid_i),
    .done_i        (done_o),
    .status_i      (status_o),
    .woken_valid_i (woken_valid_o),
    .woken_pid_i   (woken_pid_o),
    .errors_o      (err_count),
    .pending_o     (pending_count),
    .results_o     (result_count),
    .blocked_o     (blocked_count),
    .woken_o       (woken_count),
    .full_o        (full_count),
    .unknown_o     (unknown_count)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tasks below are entered and left just after a falling edge

  // One register write
  task automatic write_reg(input logic [csem_pkg::CfgIdxW-1:0]  idx,
                           input logic [csem_pkg::CfgDataW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = {$urandom, $urandom};
  endtask

  // One request transfer, optionally after a short gap
  task automatic issue(input logic                         op,
                       input logic [csem_pkg::SemIdxW-1:0] idx,
                       input logic [csem_pkg::PidW-1:0]    pid);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start       = 1'b1;
    func_i      = op;
    sem_index_i = idx;
    pid_i       = pid;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    request_count++;
  endtask

  // Hold off until every outstanding result has come back
  task automatic quiesce();
    start = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Start-count word with every byte in 0..hi
  function automatic logic [csem_pkg::CfgDataW-1:0] low_counts(int hi);
    logic [csem_pkg::CfgDataW-1:0] w;
    for (int i = 0; i < csem_pkg::CfgDataW / csem_pkg::StartCntW; i++) begin
      w[csem_pkg::StartCntW*i +: csem_pkg::StartCntW] =
        csem_pkg::StartCntW'($urandom_range(0, hi));
    end
    return w;
  endfunction

  // Configure, then run random waits and signals with a pause in the middle
  task automatic run_phase(input int                            n_items,
                           input logic [csem_pkg::SemsInUseW-1:0] limit,
                           input logic [csem_pkg::CfgDataW-1:0]   start_counts,
                           input int                            wait_pct);
    logic [csem_pkg::CfgDataW-1:0] word;
    int                            eff;
    logic                          op;
    logic [csem_pkg::SemIdxW-1:0]  idx;
    word                              = {$urandom, $urandom};
    word[csem_pkg::SemsInUseW-1:0]    = limit;
    eff                               = (limit > 8) ? 8 : int'(limit);
    write_reg(csem_pkg::CfgSemsInUse, word);
    write_reg(csem_pkg::CfgInitialCounts, start_counts);
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) quiesce();
      op = ($urandom_range(0, 99) < wait_pct) ? csem_pkg::FuncWait : csem_pkg::FuncSignal;
      if (eff == 0 || $urandom_range(0, 9) == 0) begin
        idx = csem_pkg::SemIdxW'($urandom_range(0, 15));
      end else begin
        idx = csem_pkg::SemIdxW'($urandom_range(0, eff - 1));
      end
      issue(op, idx, csem_pkg::PidW'($urandom));
    end
    quiesce();
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: three semaphores starting at 1, 0 and 255
    write_reg(csem_pkg::CfgSemsInUse, 64'd3);
    write_reg(csem_pkg::CfgInitialCounts, 64'h0000_0000_00FF_0001);
    issue(csem_pkg::FuncWait, 4'd0, 8'h00);
    // fill the queue of semaphore 1, then one more wait bounces off
    for (int k = 0; k < 17; k++) begin
      issue(csem_pkg::FuncWait, 4'd1,
            (k == 0) ? 8'hFF : (k == 1) ? 8'h00 : csem_pkg::PidW'($urandom));
    end
    issue(csem_pkg::FuncSignal, 4'd1, 8'h5A);
    issue(csem_pkg::FuncSignal, 4'd2, 8'hFF);
    issue(csem_pkg::FuncWait, 4'd3, 8'h12);
    issue(csem_pkg::FuncSignal, 4'd15, 8'h34);
    issue(csem_pkg::FuncSignal, 4'd0, 8'h00);
    quiesce();

    // Random phases over several table settings
    run_phase(150, 4'd15, {$urandom, $urandom}, 50);
    run_phase(130, 4'd8, {csem_pkg::CfgDataW{1'b1}}, 70);
    run_phase(120, 4'd1, '0, 60);
    run_phase(150, 4'd2, low_counts(3), 55);
    run_phase(30, 4'd0, {$urandom, $urandom}, 50);
    gaps_on = 1'b0;
    run_phase(200, csem_pkg::SemsInUseW'($urandom_range(1, 8)), low_counts(2), 50);

    repeat (8) @(negedge clk_i);
    $display("Sent %0d requests, checked %0d results: %0d blocked, %0d woken,",
             request_count, result_count, blocked_count, woken_count);
    $display("%0d rejected on a full queue, %0d on an unknown index.",
             full_count, unknown_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
